@@ sv/uer_pkg.sv @@
`default_nettype none
package uer_pkg;

	localparam int DIST_BITS    = 15;
	localparam int DIVISOR_BITS = 14;
	localparam int SOUND_DIV    = 58;
	localparam int PC_BITS      = 3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2,
		PH_TIME = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CFG_SAMPLE_COUNT = 2'd0,
		CFG_TIMEOUT      = 2'd1,
		CFG_TRIGGER      = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_INPUT,
		WAIT_OUTPUT
	} wait_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_FIN,
		COND_BITS_LEFT
	} cond_t;

	typedef struct packed {
		op_t                  op;
		wait_t                hold;
		cond_t                cond;
		logic [PC_BITS-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage
`default_nettype wire

@@ sv/uer_divider.sv @@
`default_nettype none
module uer_divider #(
	parameter int DVD_BITS = 29
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  uer_pkg::div_ctrl_t                   ctrl,
	input  wire  [DVD_BITS-1:0]                  dividend,
	input  wire  [7:0]                           samples,
	output logic [DVD_BITS-1:0]                  quotient
);

	localparam int DW = uer_pkg::DIVISOR_BITS;

	logic [DVD_BITS-1:0] quo_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       divisor_q;
	logic [DW:0]         trial;
	logic                ge;

	assign trial    = {rem_q, quo_q[DVD_BITS-1]};
	assign ge       = trial >= {1'b0, divisor_q};
	assign quotient = quo_q;

	// restoring division, one quotient bit per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctrl.load) begin
			rem_q <= '0;
		end else if (ctrl.step) begin
			if (ge) begin
				rem_q <= DW'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q     <= dividend;
			divisor_q <= DW'(samples) * DW'(uer_pkg::SOUND_DIV);
		end else if (ctrl.step) begin
			quo_q <= {quo_q[DVD_BITS-2:0], ge};
		end
	end

endmodule
`default_nettype wire

@@ sv/ultrasonic_echo_ranger.sv @@
// ultrasonic echo ranger
// input channel s_*: one transfer per microsecond tick. s_tuser is the command
// (0 tick, 1 start when idle), s_tdata[0] the sampled echo pin level.
// output channel m_*: exactly one result transfer per input transfer, showing
// the state after that tick: trigger level, busy, done, valid and distance.
// cfg_*: register writes (0 sample count, 1 timeout, 2 trigger length), always
// ready, to be issued only while no tick is in flight.
// an ordinary tick passes through the sequencer steps TICK, a check for a
// finished measurement and EMIT, which loads its result into the output
// register; the next tick can be taken in the cycle after that. the tick that
// ends a measurement also runs the averaging divide before EMIT: a load,
// COUNT_BITS + 8 + FRACTION_BITS quotient steps, one per cycle through the
// restoring divider (29 steps at the defaults), and a step that stores the
// distance. a new tick is taken as soon as the previous result sits in the
// output register; if the receiver stalls, the next tick is processed and
// then held until the output register frees up.
// reset clears the sequencer, the measurement state and the output valid and
// loads the register defaults (1 sample, 30000 us timeout, 20 us trigger).
`default_nettype none
module ultrasonic_echo_ranger #(
	parameter int FRACTION_BITS = 4,
	parameter int COUNT_BITS    = 17
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [0] echo_level, [7:1] zero
	input  wire         s_tuser,   // [0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
	                               // [3] valid_res, [18:4] distance, [23:19] zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_addr,
	input  wire  [16:0] cfg_data
);

	localparam int SW        = COUNT_BITS + 8;
	localparam int NB        = SW + FRACTION_BITS;
	localparam int CNTW      = $clog2(NB + 1);
	localparam int LW        = (COUNT_BITS > 17) ? COUNT_BITS : 17;
	localparam int PCW       = uer_pkg::PC_BITS;
	localparam int DB        = uer_pkg::DIST_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	function automatic uer_pkg::uword_t ucode(input logic [PCW-1:0] pc);
		uer_pkg::uword_t w;
		w = '{uer_pkg::OP_NOP, uer_pkg::WAIT_NONE, uer_pkg::COND_ALWAYS, PCW'(0)};
		case (pc)
			PCW'(0): w = '{uer_pkg::OP_TICK, uer_pkg::WAIT_INPUT,
				uer_pkg::COND_NEVER, PCW'(0)};
			PCW'(1): w = '{uer_pkg::OP_NOP, uer_pkg::WAIT_NONE,
				uer_pkg::COND_NO_FIN, PCW'(5)};
			PCW'(2): w = '{uer_pkg::OP_DIV_LOAD, uer_pkg::WAIT_NONE,
				uer_pkg::COND_NEVER, PCW'(0)};
			PCW'(3): w = '{uer_pkg::OP_DIV_STEP, uer_pkg::WAIT_NONE,
				uer_pkg::COND_BITS_LEFT, PCW'(3)};
			PCW'(4): w = '{uer_pkg::OP_DIV_DONE, uer_pkg::WAIT_NONE,
				uer_pkg::COND_NEVER, PCW'(0)};
			PCW'(5): w = '{uer_pkg::OP_EMIT, uer_pkg::WAIT_OUTPUT,
				uer_pkg::COND_ALWAYS, PCW'(0)};
			default: w = '{uer_pkg::OP_NOP, uer_pkg::WAIT_NONE,
				uer_pkg::COND_ALWAYS, PCW'(0)};
		endcase
		return w;
	endfunction

	// configuration
	logic [7:0]  sample_count_q;
	logic [16:0] timeout_q;
	logic [9:0]  trigger_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= 8'd1;
			timeout_q      <= 17'd30000;
			trigger_q      <= 10'd20;
		end else if (cfg_valid) begin
			case (uer_pkg::cfg_index_t'(cfg_addr))
				uer_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[7:0];
				uer_pkg::CFG_TIMEOUT:      timeout_q      <= cfg_data;
				uer_pkg::CFG_TRIGGER:      trigger_q      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer
	logic [PCW-1:0]  pc_q;
	logic [PCW-1:0]  pc_next;
	uer_pkg::uword_t uw;
	logic            go;
	logic            jump;
	logic            in_xfer;

	// measurement state
	uer_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_BITS-1:0] tick_q, tick_d;
	logic [7:0]            left_q, left_d;
	logic [7:0]            good_q, good_d;
	logic [SW-1:0]         sum_q, sum_d;
	logic                  fin_q, fin_d;
	logic                  fin_valid_q, fin_valid_d;
	logic [DB-1:0]         dist_q;
	logic [CNTW-1:0]       bit_cnt_q;

	logic                  out_valid_q;
	logic [23:0]           out_data_q;

	uer_pkg::div_ctrl_t    dctl;
	logic [NB-1:0]         quotient;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.hold)
			uer_pkg::WAIT_INPUT:  go = s_tvalid;
			uer_pkg::WAIT_OUTPUT: go = !out_valid_q || m_tready;
			default:              go = 1'b1;
		endcase
		case (uw.cond)
			uer_pkg::COND_ALWAYS:    jump = 1'b1;
			uer_pkg::COND_NO_FIN:    jump = !fin_q;
			uer_pkg::COND_BITS_LEFT: jump = bit_cnt_q != CNTW'(1);
			default:                 jump = 1'b0;
		endcase
		if (!go) begin
			pc_next = pc_q;
		end else if (jump) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + PCW'(1);
		end
	end

	assign s_tready = uw.hold == uer_pkg::WAIT_INPUT;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_next;
		end
	end

	// one tick of the sample timing
	logic [LW-1:0]         tick_ext;
	logic [LW-1:0]         lim;
	logic                  at_lim;
	logic [COUNT_BITS-1:0] tick_inc;
	logic                  close;
	logic                  close_good;
	logic [7:0]            left_dec;
	logic [7:0]            good_inc;

	always_comb begin
		tick_ext = LW'(tick_q);
		// a timeout beyond the counter range is capped at its top
		lim = (LW'(timeout_q) > LW'(COUNT_MAX)) ? LW'(COUNT_MAX) : LW'(timeout_q);
		at_lim   = tick_ext >= lim;
		tick_inc = tick_q + COUNT_BITS'(1);
		left_dec = left_q - 8'd1;
		good_inc = good_q + 8'd1;

		phase_d     = phase_q;
		tick_d      = tick_q;
		left_d      = left_q;
		good_d      = good_q;
		sum_d       = sum_q;
		fin_d       = 1'b0;
		fin_valid_d = 1'b0;
		close       = 1'b0;
		close_good  = 1'b0;

		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (s_tuser) begin
					left_d  = (sample_count_q == 8'd0) ? 8'd1 : sample_count_q;
					good_d  = '0;
					sum_d   = '0;
					tick_d  = '0;
					phase_d = uer_pkg::PH_TRIG;
				end
			end
			uer_pkg::PH_TRIG: begin
				tick_d = tick_inc;
				if (tick_inc >= COUNT_BITS'(trigger_q)) begin
					tick_d  = '0;
					phase_d = uer_pkg::PH_WAIT;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (s_tdata[0]) begin
					tick_d  = COUNT_BITS'(1);
					phase_d = uer_pkg::PH_TIME;
				end else if (at_lim) begin
					close = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				if (!s_tdata[0]) begin
					close      = 1'b1;
					close_good = 1'b1;
				end else if (at_lim) begin
					close = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
		endcase

		if (close) begin
			if (close_good) begin
				good_d = good_inc;
				sum_d  = sum_q + SW'(tick_q);
			end
			left_d = left_dec;
			tick_d = '0;
			if (left_dec != 8'd0) begin
				phase_d = uer_pkg::PH_TRIG;
			end else begin
				phase_d     = uer_pkg::PH_IDLE;
				fin_d       = 1'b1;
				fin_valid_d = close_good || (good_q != 8'd0);
			end
		end
	end

	logic do_op;
	assign do_op = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uer_pkg::PH_IDLE;
			tick_q      <= '0;
			left_q      <= '0;
			good_q      <= '0;
			sum_q       <= '0;
			fin_q       <= 1'b0;
			fin_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_op && (uw.op == uer_pkg::OP_EMIT)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_op) begin
				case (uw.op)
					uer_pkg::OP_TICK: begin
						if (in_xfer) begin
							phase_q     <= phase_d;
							tick_q      <= tick_d;
							left_q      <= left_d;
							good_q      <= good_d;
							sum_q       <= sum_d;
							fin_q       <= fin_d;
							fin_valid_q <= fin_valid_d;
						end
					end
					uer_pkg::OP_DIV_LOAD: bit_cnt_q <= CNTW'(NB);
					uer_pkg::OP_DIV_STEP: bit_cnt_q <= bit_cnt_q - CNTW'(1);
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_op) begin
			case (uw.op)
				uer_pkg::OP_TICK: dist_q <= '0;
				uer_pkg::OP_DIV_DONE: begin
					if (!fin_valid_q) begin
						dist_q <= '0;
					end else if (|quotient[NB-1:DB]) begin
						dist_q <= {DB{1'b1}};
					end else begin
						dist_q <= quotient[DB-1:0];
					end
				end
				uer_pkg::OP_EMIT: begin
					out_data_q <= {5'd0, dist_q, fin_valid_q, fin_q,
						phase_q != uer_pkg::PH_IDLE, phase_q == uer_pkg::PH_TRIG};
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		dctl.load = do_op && (uw.op == uer_pkg::OP_DIV_LOAD);
		dctl.step = do_op && (uw.op == uer_pkg::OP_DIV_STEP);
	end

	uer_divider #(
		.DVD_BITS(NB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctl),
		.dividend (NB'(sum_q) << FRACTION_BITS),
		.samples  (good_q),
		.quotient (quotient)
	);

endmodule
`default_nettype wire

@@ sv/uer_checker.sv @@
`default_nettype none
module uer_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// distance only comes with a finished, valid measurement
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[18:4] != 15'd0) |-> m_tdata[2] && m_tdata[3])
		else $error("distance without done and valid");

	// the finishing tick leaves the block idle with trigger low
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
		else $error("done while busy");

	// trigger only during a measurement, valid only with done
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[1]) && (!m_tdata[3] || m_tdata[2]))
		else $error("trigger or valid out of place");

endmodule

bind ultrasonic_echo_ranger uer_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/sv/uer_monitor.sv @@
module uer_monitor #(
	parameter int FRACTION_BITS = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,
	input  wire         s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [23:0] m_tdata,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [1:0]  cfg_addr,
	input  wire  [16:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          measurements,
	output int          valid_measurements,
	output int          saturated
);

	// same layout as m_tdata, lowest bit last
	typedef struct packed {
		logic [4:0]                    pad;
		logic [uer_pkg::DIST_BITS-1:0] distance;
		logic                          vld;
		logic                          fin;
		logic                          busy;
		logic                          trig;
	} reading_t;

	localparam logic [uer_pkg::DIST_BITS-1:0] DIST_CAP = '1;

	// register copies
	logic [7:0]  sample_regs;
	logic [16:0] timeout_reg;
	logic [9:0]  trigger_reg;

	// measurement state
	uer_pkg::phase_t ph;
	logic [16:0] tick_cnt;
	logic [7:0]  samples_left;
	logic [7:0]  good_cnt;
	logic [24:0] width_sum;

	reading_t pending_readings[$];
	reading_t want;
	reading_t got;

	function automatic reading_t advance_ranger(input logic start, input logic echo);
		reading_t r;
		logic closing;
		logic hit;
		logic [16:0] width;
		longint unsigned num;
		longint unsigned den;
		longint unsigned quo;
		r = '0;
		closing = 1'b0;
		hit = 1'b0;
		width = '0;
		case (ph)
			uer_pkg::PH_IDLE: begin
				if (start) begin
					samples_left = (sample_regs == 8'd0) ? 8'd1 : sample_regs;
					good_cnt = '0;
					width_sum = '0;
					tick_cnt = '0;
					ph = uer_pkg::PH_TRIG;
				end
			end
			uer_pkg::PH_TRIG: begin
				tick_cnt = tick_cnt + 17'd1;
				if (tick_cnt >= trigger_reg) begin
					tick_cnt = '0;
					ph = uer_pkg::PH_WAIT;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (echo) begin
					tick_cnt = 17'd1;
					ph = uer_pkg::PH_TIME;
				end else if (tick_cnt >= timeout_reg) begin
					closing = 1'b1;
				end else begin
					tick_cnt = tick_cnt + 17'd1;
				end
			end
			default: begin
				if (!echo) begin
					closing = 1'b1;
					hit = 1'b1;
					width = tick_cnt;
				end else if (tick_cnt >= timeout_reg) begin
					closing = 1'b1;
				end else begin
					tick_cnt = tick_cnt + 17'd1;
				end
			end
		endcase
		if (closing) begin
			if (hit) begin
				good_cnt = good_cnt + 8'd1;
				width_sum = width_sum + width;
			end
			samples_left = samples_left - 8'd1;
			tick_cnt = '0;
			if (samples_left != 8'd0) begin
				ph = uer_pkg::PH_TRIG;
			end else begin
				ph = uer_pkg::PH_IDLE;
				r.fin = 1'b1;
				r.vld = (good_cnt != 8'd0);
				if (r.vld) begin
					num = longint'(width_sum) << FRACTION_BITS;
					den = uer_pkg::SOUND_DIV * good_cnt;
					quo = num / den;
					r.distance = (quo > DIST_CAP) ? DIST_CAP : quo[uer_pkg::DIST_BITS-1:0];
				end
			end
		end
		r.trig = (ph == uer_pkg::PH_TRIG);
		r.busy = (ph != uer_pkg::PH_IDLE);
		return r;
	endfunction

	function automatic void compare_field(input string what, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_regs = 8'd1;
			timeout_reg = 17'd30000;
			trigger_reg = 10'd20;
			ph = uer_pkg::PH_IDLE;
			tick_cnt = '0;
			samples_left = '0;
			good_cnt = '0;
			width_sum = '0;
			pending_readings.delete();
			errors = 0;
			measurements = 0;
			valid_measurements = 0;
			saturated = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_readings.size() == 0) begin
					errors++;
					$display("%0t: result transfer %h expected none actual one", $time, m_tdata);
				end else begin
					want = pending_readings.pop_front();
					compare_field("trigger_level", want.trig, got.trig);
					compare_field("busy", want.busy, got.busy);
					compare_field("done", want.fin, got.fin);
					compare_field("valid", want.vld, got.vld);
					compare_field("distance", want.distance, got.distance);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					uer_pkg::CFG_SAMPLE_COUNT: sample_regs = cfg_data[7:0];
					uer_pkg::CFG_TIMEOUT:      timeout_reg = cfg_data;
					uer_pkg::CFG_TRIGGER:      trigger_reg = cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = advance_ranger(s_tuser, s_tdata[0]);
				if (want.fin) begin
					measurements++;
					if (want.vld)
						valid_measurements++;
					if (want.distance == DIST_CAP)
						saturated++;
				end
				pending_readings.push_back(want);
			end
		end
		pending = pending_readings.size();
	end

endmodule

@@ tb/sv/tb_ultrasonic_echo_ranger.sv @@
module tb_ultrasonic_echo_ranger;

	localparam int FRAC_BITS   = 4;
	localparam int CNT_BITS    = 17;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	wire  [23:0] m_tdata;
	logic        cfg_valid;
	wire         cfg_ready;
	logic [1:0]  cfg_addr;
	logic [16:0] cfg_data;

	int errors;
	int pending;
	int measurements;
	int valid_measurements;
	int saturated;

	int src_idle = 13;
	int dst_idle = 84;
	logic stall_pending = 1'b0;
	logic stall_done = 1'b0;
	int items_sent = 0;
	int quiet = 0;

	// register values as last written, used only to shape stimulus
	int cur_cnt = 1;
	int cur_tmo = 30000;
	int cur_trg = 20;

	ultrasonic_echo_ranger #(
		.FRACTION_BITS(FRAC_BITS),
		.COUNT_BITS   (CNT_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	uer_monitor #(
		.FRACTION_BITS(FRAC_BITS)
	) i_monitor (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_addr          (cfg_addr),
		.cfg_data          (cfg_data),
		.errors            (errors),
		.pending           (pending),
		.measurements      (measurements),
		.valid_measurements(valid_measurements),
		.saturated         (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pending && !stall_done) begin
				m_tready <= 1'b0;
				stall_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= dst_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("tb_ultrasonic_echo_ranger NOT OK");
				$finish;
			end
		end
	end

	function automatic logic stray_start();
		return ($urandom_range(15) == 0);
	endfunction

	// called and returns at a rising edge; leaves tvalid high after the transfer
	task automatic send_tick(input logic cmd, input logic echo);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, echo};
		s_tuser <= cmd;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic drain_readings();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_reg(input uer_pkg::cfg_index_t idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val[16:0];
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			uer_pkg::CFG_SAMPLE_COUNT: cur_cnt = val[7:0];
			uer_pkg::CFG_TIMEOUT:      cur_tmo = val[16:0];
			uer_pkg::CFG_TRIGGER:      cur_trg = val[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// measurement: trigger, echo gap, echo pulse or timeout per sample
	task automatic measure(input int gap_hi, input int width_lo, input int width_hi,
			input int fail_pct);
		int samples;
		int trg_len;
		int lim;
		int d;
		int w;
		int roll;
		samples = (cur_cnt == 0) ? 1 : cur_cnt;
		trg_len = (cur_trg == 0) ? 1 : cur_trg;
		lim = cur_tmo;
		if (lim > 64)
			fail_pct = 0;
		send_tick(1'b1, 1'($urandom_range(1)));
		repeat (samples) begin
			repeat (trg_len)
				send_tick(stray_start(), 1'($urandom_range(1)));
			roll = $urandom_range(99);
			if (roll < fail_pct / 2) begin
				// echo never arrives
				repeat (lim + 1)
					send_tick(stray_start(), 1'b0);
			end else begin
				d = $urandom_range(gap_hi);
				if (d > lim)
					d = lim;
				repeat (d)
					send_tick(stray_start(), 1'b0);
				if (roll < fail_pct) begin
					// echo stays high past the timeout
					repeat (((lim < 1) ? 1 : lim) + 1)
						send_tick(stray_start(), 1'b1);
				end else begin
					w = $urandom_range(width_hi, width_lo);
					if (w > lim)
						w = lim;
					if (w < 1)
						w = 1;
					repeat (w)
						send_tick(stray_start(), 1'b1);
					send_tick(stray_start(), 1'b0);
				end
			end
		end
	endtask

	// random ticks from a start, then enough low ticks to bring it back to idle
	task automatic scramble();
		int samples;
		int trg_len;
		samples = (cur_cnt == 0) ? 1 : cur_cnt;
		trg_len = (cur_trg == 0) ? 1 : cur_trg;
		send_tick(1'b1, 1'($urandom_range(1)));
		repeat ($urandom_range(40, 5))
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (samples * (trg_len + cur_tmo + 2))
			send_tick(1'b0, 1'b0);
	endtask

	initial begin
		int i;
		int mode;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: idle ticks, a start, a busy start, one 3 us echo
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		for (i = 0; i < 20; i++)
			send_tick(i == 3, i[0]);
		repeat (2) send_tick(1'b0, 1'b0);
		repeat (3) send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_readings();

		// zero sample count, zero timeout, zero trigger, write to the unused index
		set_reg(uer_pkg::CFG_SAMPLE_COUNT, 0);
		set_reg(uer_pkg::CFG_TIMEOUT, 0);
		set_reg(uer_pkg::CFG_TRIGGER, 0);
		set_reg(uer_pkg::CFG_UNUSED, 32'h1ffff);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);

		for (mode = 0; mode < 3; mode++) begin
			src_idle = (mode == 0) ? 13 : (mode == 1) ? 84 : 0;
			dst_idle = (mode == 0) ? 84 : (mode == 1) ? 13 : 0;
			repeat (3) begin
				drain_readings();
				set_reg(uer_pkg::CFG_SAMPLE_COUNT,
					($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(3));
				set_reg(uer_pkg::CFG_TIMEOUT, $urandom_range(16));
				set_reg(uer_pkg::CFG_TRIGGER, $urandom_range(12));
				if (mode == 2)
					stall_pending <= 1'b1;
				repeat (2) begin
					if ($urandom_range(9) == 0)
						scramble();
					else
						measure(4, 1, 16, 30);
				end
			end
		end

		// extremes, no idling
		drain_readings();
		set_reg(uer_pkg::CFG_SAMPLE_COUNT, 20);
		set_reg(uer_pkg::CFG_TIMEOUT, 1);
		set_reg(uer_pkg::CFG_TRIGGER, 0);
		measure(1, 1, 1, 30);
		drain_readings();
		set_reg(uer_pkg::CFG_TIMEOUT, 100000);
		set_reg(uer_pkg::CFG_SAMPLE_COUNT, 3);
		set_reg(uer_pkg::CFG_TRIGGER, 10);
		measure(8, 1, 40, 0);

		drain_readings();
		repeat (50) @(posedge clk);
		$display("%0d ticks sent, %0d measurements finished, %0d valid, %0d saturated",
			items_sent, measurements, valid_measurements, saturated);
		$display("zero and small register values, a long timeout, three idle mixes, one long stall");
		if (errors == 0 && pending == 0)
			$display("tb_ultrasonic_echo_ranger OK");
		else
			$display("tb_ultrasonic_echo_ranger NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
sv/uer_pkg.sv
sv/uer_divider.sv
sv/ultrasonic_echo_ranger.sv
sv/uer_checker.sv
tb/sv/uer_monitor.sv
tb/sv/tb_ultrasonic_echo_ranger.sv
